[rtl/scaled_clipped_bitmap_blit_defines.svh]
// assertion macros for the blitter rtl
`ifndef SCALED_CLIPPED_BITMAP_BLIT_DEFINES_SVH
`define SCALED_CLIPPED_BITMAP_BLIT_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SCB_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger at one edge implies the consequence at the next edge
`define SCB_CHECK_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[rtl/scb_pkg.sv]
// shared types, codes and helpers of the bitmap blitter
`timescale 1ns / 1ps
package scb_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_VIEW_LEFT  = 3'd2;
  localparam logic [2:0] CFG_VIEW_TOP   = 3'd3;
  localparam logic [2:0] CFG_VIEW_RIGHT = 3'd4;
  localparam logic [2:0] CFG_VIEW_BOT   = 3'd5;

  localparam int FRAME_WIDTH = 640;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 64;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        src_index;
    logic [14:0]        src_color;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [9:0]         zoom_w;
    logic [9:0]         zoom_h;
  } cmd_t;

  typedef struct packed {
    logic [6:0] src_width;
    logic [6:0] src_height;
    logic [9:0] view_left;
    logic [9:0] view_top;
    logic [9:0] view_right;
    logic [9:0] view_bottom;
  } cfg_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

[rtl/scb_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module scb_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/scb_front.sv]
// front end: config registers, input unpacking and request filtering
`timescale 1ns / 1ps
module scb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [9:0]                        cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [scb_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output scb_pkg::cmd_t                     q_cmd,
  output scb_pkg::cfg_t                     cfg
);
  import scb_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width   <= 7'd32;
      cfg_r.src_height  <= 7'd32;
      cfg_r.view_left   <= 10'd0;
      cfg_r.view_top    <= 10'd0;
      cfg_r.view_right  <= 10'd639;
      cfg_r.view_bottom <= 10'd479;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  cfg_r.src_width   <= cfg_wdata[6:0];
        CFG_SRC_HEIGHT: cfg_r.src_height  <= cfg_wdata[6:0];
        CFG_VIEW_LEFT:  cfg_r.view_left   <= cfg_wdata;
        CFG_VIEW_TOP:   cfg_r.view_top    <= cfg_wdata;
        CFG_VIEW_RIGHT: cfg_r.view_right  <= cfg_wdata;
        CFG_VIEW_BOT:   cfg_r.view_bottom <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign in_tready = !q_full;

  // unused request code is swallowed here
  assign q_push = in_tvalid && !q_full && (in_tuser != REQ_NONE);

  always_comb begin
    q_cmd.kind      = in_tuser;
    q_cmd.src_index = in_tdata[11:0];
    q_cmd.src_color = in_tdata[26:12];
    q_cmd.dest_x    = in_tdata[38:27];
    q_cmd.dest_y    = in_tdata[50:39];
    q_cmd.zoom_w    = in_tdata[60:51];
    q_cmd.zoom_h    = in_tdata[70:61];
  end
endmodule

[rtl/scb_queue.sv]
// two entry command queue between front and back
`timescale 1ns / 1ps
module scb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output scb_pkg::cmd_t head
);
  import scb_pkg::*;

  cmd_t       slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = slot_r[rptr_r];
endmodule

[rtl/scb_back.sv]
// back end: clip setup, source store and pixel walk
`timescale 1ns / 1ps
`include "scaled_clipped_bitmap_blit_defines.svh"
module scb_back #(
  parameter int SRC_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  scb_pkg::cfg_t                      cfg,
  input  logic                               cmd_valid,
  input  scb_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [scb_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);
  import scb_pkg::*;

  localparam int AW = $clog2(SRC_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CATCH = 3'd2;
  localparam logic [2:0] ST_CLIP  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_r;
  logic       busy_r, phase_r, catch_row_r;
  logic [9:0] cur_col_r, cur_row_r, first_col_r, end_col_r, end_row_r;
  logic [6:0] src_col_r, src_col_first_r, src_row_r, sxs_r;
  logic signed [11:0] col_bal_r, col_bal_first_r, row_bal_r, bx_r;
  logic [9:0] zw_r, zh_r;
  cmd_t       cmd_r;
  logic [9:0] xs_r, xe_r, ys_r, ye_r, left_r, up_r;
  logic [16:0] num_r;
  logic [10:0] rem_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [14:0]   ram_rdata;
  logic [31:0]   load_full, read_full;

  assign load_full = 32'(cmd.src_index);
  assign read_full = 32'(src_row_r) * 32'(cfg.src_width) + 32'(src_col_r);
  assign ram_waddr = load_full[AW-1:0];
  assign ram_raddr = read_full[AW-1:0];

  logic out_free;
  assign out_free = !out_valid_r || out_tready;
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid &&
                    ((cmd.kind != REQ_STEP) || out_free);
  assign ram_we   = cmd_pop && (cmd.kind == REQ_LOAD);

  scb_ram #(.WIDTH(15), .DEPTH(SRC_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.src_color),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clip geometry in 14-bit signed
  logic signed [13:0] x0, y0, xend, yend, vx0, vy0, vx1, vy1, xs, xe, ys, ye;
  logic signed [13:0] left, up;
  logic               empty;
  always_comb begin
    x0   = 14'(cmd_r.dest_x);
    y0   = 14'(cmd_r.dest_y);
    xend = x0 + $signed({4'd0, cmd_r.zoom_w}) - 14'sd1;
    yend = y0 + $signed({4'd0, cmd_r.zoom_h}) - 14'sd1;
    vx0  = $signed({4'd0, cfg.view_left});
    vy0  = $signed({4'd0, cfg.view_top});
    vx1  = $signed({4'd0, cfg.view_right});
    vy1  = $signed({4'd0, cfg.view_bottom});
    xs   = (x0 < vx0) ? vx0 : x0;
    ys   = (y0 < vy0) ? vy0 : y0;
    xe   = (vx1 < xend) ? vx1 : xend;
    ye   = (vy1 < yend) ? vy1 : yend;
    left = (x0 < vx0) ? (vx0 - x0) : 14'sd0;
    up   = (y0 < vy0) ? (vy0 - y0) : 14'sd0;
    empty = (cmd_r.zoom_w == 10'd0) || (cmd_r.zoom_h == 10'd0) ||
            (xs > xe) || (ys > ye);
  end

  // restoring divider step, shared by the column and row seeds
  logic [10:0] div_d, div_t;
  logic        div_ge;
  always_comb begin
    div_d  = phase_r ? {1'b0, cmd_r.zoom_h} : {1'b0, cmd_r.zoom_w};
    div_t  = {rem_r[9:0], num_r[16]};
    div_ge = (div_t >= div_d);
  end

  // balance updates
  logic signed [11:0] col_sub, row_sub, catch_bal, catch_sum;
  always_comb begin
    col_sub   = col_bal_r - $signed({5'd0, cfg.src_width});
    row_sub   = row_bal_r - $signed({5'd0, cfg.src_height});
    catch_bal = catch_row_r ? row_bal_r : col_bal_r;
    catch_sum = catch_bal + (catch_row_r ? $signed({2'd0, zh_r}) : $signed({2'd0, zw_r}));
  end

  logic [20:0] addr_full;
  assign addr_full = 21'(cur_row_r) * 21'(FRAME_WIDTH) + 21'(cur_col_r);

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (state_r == ST_READ) begin
        out_data_r <= {widen5(ram_rdata[4:0]), widen5(ram_rdata[14:10]),
                       widen5(ram_rdata[9:5]), addr_full[19:0], cur_row_r, cur_col_r};
        out_last_r <= (cur_col_r >= end_col_r) && (cur_row_r >= end_row_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      catch_row_r <= 1'b0;
      cnt_r       <= 5'd0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.kind == REQ_START) begin
              cmd_r   <= cmd;
              busy_r  <= 1'b0;
              state_r <= ST_CLIP;
            end else if (cmd.kind == REQ_STEP && busy_r) begin
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          out_valid_r <= 1'b1;
          if (cur_col_r < end_col_r) begin
            cur_col_r <= cur_col_r + 10'd1;
            col_bal_r <= col_sub;
            catch_row_r <= 1'b0;
            state_r   <= (col_sub <= 12'sd0) ? ST_CATCH : ST_IDLE;
          end else if (cur_row_r < end_row_r) begin
            cur_row_r <= cur_row_r + 10'd1;
            row_bal_r <= row_sub;
            cur_col_r <= first_col_r;
            src_col_r <= src_col_first_r;
            col_bal_r <= col_bal_first_r;
            catch_row_r <= 1'b1;
            state_r   <= (row_sub <= 12'sd0) ? ST_CATCH : ST_IDLE;
          end else begin
            busy_r  <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        ST_CATCH: begin
          // one source step per cycle until the balance turns positive
          if (catch_row_r) begin
            row_bal_r <= catch_sum;
            src_row_r <= src_row_r + 7'd1;
          end else begin
            col_bal_r <= catch_sum;
            src_col_r <= src_col_r + 7'd1;
          end
          if (catch_sum > 12'sd0) state_r <= ST_IDLE;
        end
        ST_CLIP: begin
          xs_r    <= xs[9:0];
          xe_r    <= xe[9:0];
          ys_r    <= ys[9:0];
          ye_r    <= ye[9:0];
          left_r  <= left[9:0];
          up_r    <= up[9:0];
          phase_r <= 1'b0;
          state_r <= empty ? ST_IDLE : ST_MUL;
        end
        ST_MUL: begin
          num_r   <= phase_r ? (17'(cfg.src_height) * 17'(up_r))
                             : (17'(cfg.src_width) * 17'(left_r));
          rem_r   <= 11'd0;
          cnt_r   <= 5'd0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= div_ge ? (div_t - div_d) : div_t;
          num_r <= {num_r[15:0], div_ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!phase_r) begin
            sxs_r   <= num_r[6:0];
            bx_r    <= $signed({1'b0, div_d}) - $signed({1'b0, rem_r});
            phase_r <= 1'b1;
            state_r <= ST_MUL;
          end else begin
            busy_r          <= 1'b1;
            cur_col_r       <= xs_r;
            first_col_r     <= xs_r;
            end_col_r       <= xe_r;
            cur_row_r       <= ys_r;
            end_row_r       <= ye_r;
            src_col_r       <= sxs_r;
            src_col_first_r <= sxs_r;
            src_row_r       <= num_r[6:0];
            col_bal_r       <= bx_r;
            col_bal_first_r <= bx_r;
            row_bal_r       <= $signed({1'b0, div_d}) - $signed({1'b0, rem_r});
            zw_r            <= cmd_r.zoom_w;
            zh_r            <= cmd_r.zoom_h;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `SCB_CHECK(a_walk_busy, (state_r != ST_READ && state_r != ST_CATCH) || busy_r, "walk without busy")
  `SCB_CHECK(a_catch_neg, state_r != ST_CATCH || catch_bal <= 12'sd0, "catch-up on positive balance")
  `SCB_CHECK_NEXT(a_read_out, state_r == ST_READ, out_valid_r, "read did not fill output")
  `SCB_CHECK(a_step_room, !(cmd_pop && cmd.kind == REQ_STEP) || out_free, "step popped with output full")
endmodule

[rtl/scaled_clipped_bitmap_blit.sv]
// top level of the scaled and clipped bitmap blitter
// a load passes through the queue and is written into the store when the back end is idle
// a step with a blit running passes through the queue and the read state into the output
//   register; each source pixel stepped over adds a catch-up step before the next request
// a start runs clip in the back end, then two multiply and divide seeds unless the clip is empty
// the back end sequencer takes requests only while idle; a step also waits for a free output
// reset: synchronous active-low rst_n clears queue, walk control and output valid; store keeps data
`timescale 1ns / 1ps
module scaled_clipped_bitmap_blit #(
  parameter int SRC_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port, no read-back
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // src_index[11:0], src_color[26:12], dest_x[38:27], dest_y[50:39],
  // zoom_w[60:51], zoom_h[70:61], zero pad[71]
  input  logic [71:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  // pixel write stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_x[9:0], pixel_y[19:10], pixel_addr[39:20], red[47:40], green[55:48],
  // blue[63:56]
  output logic [63:0] out_tdata,
  // last_pixel
  output logic        out_tlast
);
  import scb_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_valid, q_pop;

  // front: config registers and request decode
  scb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .cfg       (cfg)
  );

  // decouples request intake from the walk
  scb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  // back: source store, clip seeding and raster walk
  scb_back #(.SRC_DEPTH(SRC_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (q_valid),
    .cmd        (head_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule
